// ===== rtl/wheel_speed_from_pulse_period_top_assert.svh =====
`ifndef WHEEL_SPEED_FROM_PULSE_PERIOD_TOP_ASSERT_SVH
`define WHEEL_SPEED_FROM_PULSE_PERIOD_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WSP_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wsp assertion failed");

// next-cycle implication, disabled in reset
`define WSP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wsp assertion failed");

`endif

// ===== rtl/wsp_pkg.sv =====
package wsp_pkg;

  localparam int unsigned TIME_WIDTH_DEF  = 48;
  localparam int unsigned SPEED_WIDTH_DEF = 32;

  localparam int unsigned CIRC_W = 16;
  localparam int unsigned TOUT_W = 32;
  localparam int unsigned CFG_W  = 32;

  localparam int unsigned US_W   = 20;
  localparam int unsigned NUM_W  = CIRC_W + US_W;

  localparam logic [US_W-1:0]   US_PER_SECOND = US_W'(1000000);
  localparam logic [CIRC_W-1:0] CIRC_RESET    = CIRC_W'(1277);
  localparam logic [TOUT_W-1:0] TOUT_RESET    = TOUT_W'(3000000);

  typedef enum logic {
    CFG_CIRC = 1'b0,
    CFG_TOUT = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/wsp_div.sv =====
module wsp_div import wsp_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [TIME_WIDTH-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int unsigned DW    = ((TIME_WIDTH > NUM_W) ? TIME_WIDTH : NUM_W) + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic                  busy_q, busy_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [NUM_W-1:0]      num_q, num_d;
  logic [NUM_W-1:0]      quo_q, quo_d;
  logic [DW-2:0]         rem_q, rem_d;
  logic [TIME_WIDTH-1:0] den_q, den_d;
  logic [DW-1:0]         trial;
  logic [DW-1:0]         den_x;
  logic                  fits;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign den_x = DW'(den_q);
  assign fits  = (trial >= den_x);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      num_d  = num_i;
      quo_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? (DW-1)'(trial - den_x) : trial[DW-2:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      num_d = {num_q[NUM_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quo_o  = quo_q;

endmodule

// ===== rtl/wheel_speed_from_pulse_period_top.sv =====
// Period-based wheel tachometer.
// Input channel: in_valid_i / in_stall_o carry one word, a microsecond
// timestamp and a pulse flag. Output channel: out_valid_o / out_stall_i
// carry one word per input word, the speed in circumference units per
// second and a stopped flag. Configuration: cfg_we_i writes cfg_wdata_i to
// register cfg_idx_i (0 = wheel circumference, 1 = stop timeout in us).
// A pulse that follows an earlier pulse runs a radix-2 divide of
// circumference * 1000000 by the period (a zero period gives the maximum
// speed): a multiply step, the divide steps, a saturate step and a write
// step, in that order. All other words go straight to the write step. The
// divider steps one quotient bit per cycle; in_stall_o is high until the
// word is finished, so a new word is taken only after the last one is done.
// When the receiver stalls, the finished word waits in the output register;
// a new input word is still accepted and worked on, and stalls only when its
// own result is ready to be written. Reset clears the pulse history and the
// speed, and loads the default circumference (1277) and timeout (3000000).
module wheel_speed_from_pulse_period_top import wsp_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int unsigned SPEED_WIDTH = SPEED_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [TIME_WIDTH-1:0]  timestamp_us_i,
  input  logic                   pulse_seen_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SPEED_WIDTH-1:0] speed_per_second_o,
  output logic                   stopped_o
);

`include "wheel_speed_from_pulse_period_top_assert.svh"

  localparam int unsigned QX = (NUM_W > SPEED_WIDTH) ? NUM_W : SPEED_WIDTH;
  localparam logic [SPEED_WIDTH-1:0] SPEED_MAX = {SPEED_WIDTH{1'b1}};

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_WB   = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [CIRC_W-1:0]      circ_q;
  logic [TOUT_W-1:0]      tout_q;
  logic [TIME_WIDTH-1:0]  last_q, last_d;
  logic                   seen_q, seen_d;
  logic [SPEED_WIDTH-1:0] speed_q, speed_d;
  logic                   stop_q, stop_d;
  logic [TIME_WIDTH-1:0]  den_q, den_d;
  logic                   ovld_q, ovld_d;
  logic [SPEED_WIDTH-1:0] ospeed_q, ospeed_d;
  logic                   ostop_q, ostop_d;

  logic                   in_acc;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   div_start;
  logic                   div_done;
  logic [NUM_W-1:0]       div_num;
  logic [NUM_W-1:0]       div_quo;
  logic [QX-1:0]          quo_x;
  logic                   wb_go;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign elapsed   = timestamp_us_i - last_q;
  assign div_start = (state_q == ST_MUL);
  assign div_num   = NUM_W'(circ_q) * NUM_W'(US_PER_SECOND);
  assign quo_x     = QX'(div_quo);
  assign wb_go     = !ovld_q || !out_stall_i;

  wsp_div #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d  = state_q;
    last_d   = last_q;
    seen_d   = seen_q;
    speed_d  = speed_q;
    stop_d   = stop_q;
    den_d    = den_q;
    ovld_d   = ovld_q && out_stall_i;
    ospeed_d = ospeed_q;
    ostop_d  = ostop_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_WB;
          if (pulse_seen_i) begin
            last_d = timestamp_us_i;
            seen_d = 1'b1;
            stop_d = 1'b0;
            if (seen_q) begin
              if (elapsed == '0) begin
                speed_d = SPEED_MAX;
              end else begin
                den_d   = elapsed;
                state_d = ST_MUL;
              end
            end
          end else if (!seen_q || (elapsed > TIME_WIDTH'(tout_q))) begin
            speed_d = '0;
            stop_d  = 1'b1;
          end else begin
            stop_d = 1'b0;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        speed_d = (quo_x > QX'(SPEED_MAX)) ? SPEED_MAX : SPEED_WIDTH'(div_quo);
        state_d = ST_WB;
      end
      ST_WB: begin
        if (wb_go) begin
          ovld_d   = 1'b1;
          ospeed_d = speed_q;
          ostop_d  = stop_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      circ_q  <= CIRC_RESET;
      tout_q  <= TOUT_RESET;
      last_q  <= '0;
      seen_q  <= 1'b0;
      speed_q <= '0;
      stop_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      seen_q  <= seen_d;
      speed_q <= speed_d;
      stop_q  <= stop_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CIRC: circ_q <= cfg_wdata_i[CIRC_W-1:0];
          CFG_TOUT: tout_q <= cfg_wdata_i[TOUT_W-1:0];
          default:  circ_q <= circ_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    den_q    <= den_d;
    ospeed_q <= ospeed_d;
    ostop_q  <= ostop_d;
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = ovld_q;
  assign speed_per_second_o = ospeed_q;
  assign stopped_o          = ostop_q;

  `WSP_ASSERT_NEXT(a_no_div_without_pulse, clk_i, rst_ni,
                   in_acc && !pulse_seen_i, state_q == ST_WB)
  `WSP_ASSERT_NOW(a_stopped_means_zero, clk_i, rst_ni,
                  out_valid_o && stopped_o, speed_per_second_o == '0)
  `WSP_ASSERT_NOW(a_done_only_in_div, clk_i, rst_ni,
                  div_done, state_q == ST_DIV)
  `WSP_ASSERT_NEXT(a_pulse_sets_seen, clk_i, rst_ni,
                   in_acc && pulse_seen_i, seen_q && !stop_q)

endmodule

// ===== dv/wheel_speed_from_pulse_period_top_tb.sv =====
`timescale 1ns / 1ps

module wheel_speed_from_pulse_period_top_tb import wsp_pkg::*;;

  localparam int unsigned TW = TIME_WIDTH_DEF;
  localparam int unsigned SW = SPEED_WIDTH_DEF;
  localparam int unsigned STUCK_LIMIT = 5000;
  localparam int unsigned PHASE_WORDS = 240;
  localparam logic [63:0] USEC_PER_SEC = 64'd1000000;

  typedef struct packed {
    logic [TW-1:0] stamp;
    logic          pulse;
  } sample_t;

  typedef struct packed {
    logic [SW-1:0] speed;
    logic          stopped;
  } speed_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_CIRC;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [TW-1:0] timestamp_us_i = '0;
  logic pulse_seen_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [SW-1:0] speed_per_second_o;
  logic stopped_o;

  sample_t     pending_samples[$];
  speed_word_t expected_speeds[$];

  int unsigned idle_pct = 18;
  int unsigned stall_pct = 18;
  int unsigned err_count = 0;
  int unsigned stuck_cycles = 0;

  // tachometer state as the block should hold it
  logic [CIRC_W-1:0] circ_reg = CIRC_RESET;
  logic [TOUT_W-1:0] tout_reg = TOUT_RESET;
  logic [TW-1:0]     last_stamp = '0;
  logic              have_pulse = 1'b0;
  logic [SW-1:0]     cur_speed = '0;

  // stimulus time cursor
  logic [TW-1:0] gen_now = '0;
  logic [TW-1:0] gen_last = '0;

  wheel_speed_from_pulse_period_top u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .timestamp_us_i     (timestamp_us_i),
    .pulse_seen_i       (pulse_seen_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .speed_per_second_o (speed_per_second_o),
    .stopped_o          (stopped_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic speed_word_t predict_speed(logic [TW-1:0] now, logic pulse);
    logic [TW-1:0] delta;
    logic [TW-1:0] gap;
    logic [63:0]   quo;
    speed_word_t   res;
    res.stopped = 1'b0;
    if (pulse) begin
      if (have_pulse) begin
        delta = now - last_stamp;
        if (delta == '0) begin
          cur_speed = '1;
        end else begin
          quo = (64'(circ_reg) * USEC_PER_SEC) / 64'(delta);
          cur_speed = (quo[63:SW] != '0) ? '1 : quo[SW-1:0];
        end
      end
      last_stamp = now;
      have_pulse = 1'b1;
    end
    gap = now - last_stamp;
    if (!have_pulse || gap > TW'(tout_reg)) begin
      cur_speed = '0;
      res.stopped = 1'b1;
    end
    res.speed = cur_speed;
    return res;
  endfunction

  task automatic add_sample(logic [TW-1:0] stamp, logic pulse);
    pending_samples.push_back('{stamp: stamp, pulse: pulse});
    gen_now = stamp;
    if (pulse) gen_last = stamp;
  endtask

  task automatic add_random_sample();
    int unsigned sel;
    logic [TW-1:0] stamp;
    logic pulse;
    sel = $urandom_range(99);
    pulse = ($urandom_range(99) < 65);
    stamp = gen_now;
    if (sel < 45) begin
      stamp = gen_now + TW'($urandom_range(100, 300000));
    end else if (sel < 60) begin
      stamp = gen_now + TW'($urandom_range(0, 80));
    end else if (sel < 72) begin
      stamp = gen_last + TW'(tout_reg) + TW'($urandom_range(3)) - TW'(1);
      pulse = ($urandom_range(3) == 0);
    end else if (sel < 82) begin
      stamp = gen_now + TW'($urandom_range(1, 5000000));
    end else if (sel < 92) begin
      stamp = TW'({$urandom, $urandom});
    end else begin
      stamp = {TW{1'b1}} - TW'($urandom_range(50));
    end
    add_sample(stamp, pulse);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_speeds.size() != 0);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= CFG_W'($urandom);
    case (idx)
      CFG_CIRC: circ_reg = data[CIRC_W-1:0];
      CFG_TOUT: tout_reg = data[TOUT_W-1:0];
      default: ;
    endcase
  endtask

  // drive input words; hold the word while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_i <= 1'b1;
        timestamp_us_i <= pending_samples[0].stamp;
        pulse_seen_i <= pending_samples[0].pulse;
        void'(pending_samples.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // stall the output, predict accepted inputs, check accepted outputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (expected_speeds.size() == 0) begin
          $error("unexpected word: speed_per_second %0d stopped %0d",
                 speed_per_second_o, stopped_o);
          err_count++;
        end else begin
          if (speed_per_second_o !== expected_speeds[0].speed) begin
            $error("speed_per_second: expected %0d, got %0d",
                   expected_speeds[0].speed, speed_per_second_o);
            err_count++;
          end
          if (stopped_o !== expected_speeds[0].stopped) begin
            $error("stopped: expected %0d, got %0d",
                   expected_speeds[0].stopped, stopped_o);
            err_count++;
          end
          void'(expected_speeds.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o)
        expected_speeds.push_back(predict_speed(timestamp_us_i, pulse_seen_i));
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("wheel_speed_from_pulse_period_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [CIRC_W-1:0] circ_w;
    logic [TOUT_W-1:0] tout_w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_sample(TW'(0), 1'b0);
    add_sample(TW'(100), 1'b1);
    add_sample(TW'(100), 1'b1);
    add_sample(TW'(1100), 1'b1);
    add_sample(TW'(1200), 1'b1);
    add_sample(TW'(3001200), 1'b0);
    add_sample(TW'(3001201), 1'b0);
    add_sample(TW'(3001202), 1'b1);
    add_sample(TW'(3001201), 1'b0);
    add_sample({TW{1'b1}}, 1'b1);
    add_sample(TW'(5), 1'b1);
    add_sample(TW'(6), 1'b1);
    add_sample(48'h5555_5555_5555, 1'b0);
    add_sample(48'hAAAA_AAAA_AAAA, 1'b1);
    wait_idle();

    // zero circumference, zero timeout
    write_cfg(CFG_CIRC, {16'hBEEF, 16'h0000});
    write_cfg(CFG_TOUT, '0);
    @(negedge clk_i);
    add_sample(TW'(7), 1'b1);
    add_sample(TW'(7), 1'b0);
    add_sample(TW'(8), 1'b0);
    add_sample(TW'(20), 1'b1);
    add_sample(TW'(20), 1'b1);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin circ_w = '1; tout_w = '1; end
        1: begin circ_w = CIRC_W'(1); tout_w = TOUT_W'(1); end
        2: begin circ_w = CIRC_RESET; tout_w = TOUT_RESET; end
        3: begin circ_w = CIRC_W'($urandom); tout_w = TOUT_W'($urandom); end
        4: begin
          circ_w = CIRC_W'($urandom_range(1, 65535));
          tout_w = TOUT_W'($urandom_range(1, 400000));
        end
        default: begin
          circ_w = CIRC_W'($urandom_range(1, 65535));
          tout_w = TOUT_W'($urandom_range(100000, 6000000));
        end
      endcase
      write_cfg(CFG_CIRC, {16'($urandom), circ_w});
      write_cfg(CFG_TOUT, tout_w);
      idle_pct = (p == 2) ? 0 : 18;
      stall_pct = (p == 2) ? 0 : 18;
      @(negedge clk_i);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        add_random_sample();
        // hold off the sender until the block has drained
        if (p == 4 && i == PHASE_WORDS / 2) wait_idle();
      end
      wait_idle();
    end

    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
    if (err_count == 0) begin
      $display("wheel_speed_from_pulse_period_top_tb OK");
    end else begin
      $display("wheel_speed_from_pulse_period_top_tb NOT OK");
    end
    $finish;
  end

endmodule
